// ===== hdl/lcr_pkg.sv =====
// Shared constants, register indexes, types and helpers of the load cell serial reader.
package lcr_pkg;

  localparam int DATA_BITS_DEF  = 24;
  localparam int TICK_WIDTH_DEF = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_PULSES   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_AVERAGE_COUNT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARE_OFFSET   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_RECIP   = 3'd4;

  localparam int GAIN_W    = 2;
  localparam int HALF_W    = 16;
  localparam int COUNT_W   = 8;
  localparam int RESULT_W  = 24;
  localparam int RECIP_W   = 32;
  localparam int SUM_W     = 32;
  localparam int UNITS_W   = 40;
  localparam int PRODUCT_W = RESULT_W + RECIP_W;
  localparam int FRAC_W    = 16;

  localparam logic [GAIN_W-1:0]   GAIN_RST  = 2'd1;
  localparam logic [HALF_W-1:0]   HALF_RST  = 16'd20;
  localparam logic [COUNT_W-1:0]  COUNT_RST = 8'd1;
  localparam logic [RESULT_W-1:0] TARE_RST  = 24'd0;
  localparam logic [RECIP_W-1:0]  RECIP_RST = 32'h0001_0000;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_pulses;
    logic [HALF_W-1:0]   half_period_ticks;
    logic [COUNT_W-1:0]  average_count;
    logic [RESULT_W-1:0] tare_offset;
    logic [RECIP_W-1:0]  scale_reciprocal;
  } lcr_cfg_t;

  typedef struct packed {
    logic shift_clr;
    logic shift_en;
    logic shift_bit;
    logic sum_clr;
    logic sum_add;
    logic div_start;
    logic div_step;
    logic net_load;
    logic mul_load;
    logic out_tick;
    logic out_result;
    logic sck;
    logic busy;
  } lcr_cmd_t;

  typedef struct packed {
    logic div_last;
  } lcr_stat_t;

  // A count of zero is handled as one.
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
    return (c == '0) ? COUNT_W'(1) : c;
  endfunction

endpackage

// ===== hdl/lcr_if.sv =====
// Channel interfaces of the load cell serial reader: tick samples in, tick results out.
interface lcr_tick_if;
  logic valid;
  logic ready;
  logic dout_level;
  logic start_measure;
  logic power_down;

  modport source (output valid, output dout_level, output start_measure,
                  output power_down, input ready);
  modport sink (input valid, input dout_level, input start_measure,
                input power_down, output ready);
endinterface

interface lcr_result_if;
  logic                          valid;
  logic                          ready;
  logic                          sck_level;
  logic                          busy_res;
  logic                          result_valid;
  logic [lcr_pkg::RESULT_W-1:0]  raw_average;
  logic [lcr_pkg::RESULT_W-1:0]  net_value;
  logic [lcr_pkg::UNITS_W-1:0]   scaled_units;

  modport source (output valid, output sck_level, output busy_res, output result_valid,
                  output raw_average, output net_value, output scaled_units, input ready);
  modport sink (input valid, input sck_level, input busy_res, input result_valid,
                input raw_average, input net_value, input scaled_units, output ready);
endinterface

// ===== hdl/lcr_datapath.sv =====
// Datapath of the load cell serial reader: shift register, sum, divider, tare and scale.
module lcr_datapath #(
  parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEF
) (
  input  logic                         clk,
  input  lcr_pkg::lcr_cmd_t            cmd,
  input  lcr_pkg::lcr_cfg_t            cfg,
  output lcr_pkg::lcr_stat_t           stat,
  output logic                         sck_level,
  output logic                         busy_res,
  output logic                         result_valid,
  output logic [lcr_pkg::RESULT_W-1:0] raw_average,
  output logic [lcr_pkg::RESULT_W-1:0] net_value,
  output logic [lcr_pkg::UNITS_W-1:0]  scaled_units
);

  localparam int DIV_CW = $clog2(lcr_pkg::SUM_W);

  logic [DATA_BITS-1:0]           shift_reg;
  logic [lcr_pkg::SUM_W-1:0]      sum;
  logic [lcr_pkg::COUNT_W-1:0]    rem;
  logic [DIV_CW-1:0]              div_cnt;
  logic [lcr_pkg::RESULT_W-1:0]   net;
  logic [lcr_pkg::PRODUCT_W-1:0]  product;

  logic [lcr_pkg::COUNT_W-1:0]    divisor;
  logic [lcr_pkg::COUNT_W:0]      partial;
  logic                           fits;
  logic [lcr_pkg::COUNT_W:0]      diff;
  logic [lcr_pkg::SUM_W-1:0]      reading;
  logic [lcr_pkg::RESULT_W-1:0]   raw;

  // Restoring division of the sum by the reading count, one quotient bit a cycle.
  always_comb begin
    divisor = lcr_pkg::eff_count(cfg.average_count);
    partial = {rem, sum[lcr_pkg::SUM_W-1]};
    fits    = partial >= {1'b0, divisor};
    diff    = partial - {1'b0, divisor};
    reading = lcr_pkg::SUM_W'(shift_reg ^ (DATA_BITS'(1) << (DATA_BITS - 1)));
    raw     = sum[lcr_pkg::RESULT_W-1:0];
    stat.div_last = (div_cnt == DIV_CW'(lcr_pkg::SUM_W - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_clr) begin
      shift_reg <= '0;
    end else if (cmd.shift_en) begin
      shift_reg <= {shift_reg[DATA_BITS-2:0], cmd.shift_bit};
    end

    if (cmd.sum_clr) begin
      sum <= '0;
    end else if (cmd.sum_add) begin
      sum <= sum + reading;
    end else if (cmd.div_step) begin
      sum <= {sum[lcr_pkg::SUM_W-2:0], fits};
    end

    if (cmd.div_start) begin
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= fits ? diff[lcr_pkg::COUNT_W-1:0] : partial[lcr_pkg::COUNT_W-1:0];
      div_cnt <= div_cnt + DIV_CW'(1);
    end

    if (cmd.net_load) begin
      net <= (raw > cfg.tare_offset) ? raw - cfg.tare_offset : '0;
    end

    if (cmd.mul_load) begin
      product <= lcr_pkg::PRODUCT_W'(net) * lcr_pkg::PRODUCT_W'(cfg.scale_reciprocal);
    end

    if (cmd.out_result) begin
      sck_level    <= 1'b0;
      busy_res     <= 1'b0;
      result_valid <= 1'b1;
      raw_average  <= raw;
      net_value    <= net;
      scaled_units <= product[lcr_pkg::FRAC_W +: lcr_pkg::UNITS_W];
    end else if (cmd.out_tick) begin
      sck_level    <= cmd.sck;
      busy_res     <= cmd.busy;
      result_valid <= 1'b0;
      raw_average  <= '0;
      net_value    <= '0;
      scaled_units <= '0;
    end
  end

endmodule

// ===== hdl/lcr_ctrl.sv =====
// Controller of the load cell serial reader: clock phases, pulse and reading counts.
module lcr_ctrl #(
  parameter int DATA_BITS          = lcr_pkg::DATA_BITS_DEF,
  parameter int TICK_COUNTER_WIDTH = lcr_pkg::TICK_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               dout_level,
  input  logic               start_measure,
  input  logic               power_down,
  input  logic               out_ready,
  output logic               out_valid,
  input  lcr_pkg::lcr_cfg_t  cfg,
  input  lcr_pkg::lcr_stat_t stat,
  output lcr_pkg::lcr_cmd_t  cmd
);

  localparam int TCW = TICK_COUNTER_WIDTH;
  localparam int PCW = $clog2(DATA_BITS + 4);
  localparam int HW  = (TCW + 1 > lcr_pkg::HALF_W + 1) ? TCW + 1 : lcr_pkg::HALF_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT, S_HIGH, S_LOW, S_DIV, S_NET, S_MUL, S_PUSH
  } state_t;

  state_t                      state, state_next;
  logic [TCW-1:0]              tick_cnt, tick_cnt_next;
  logic [PCW-1:0]              pulse_cnt, pulse_cnt_next;
  logic [lcr_pkg::COUNT_W-1:0] readings, readings_next;
  logic                        out_valid_next;

  logic                        accept;
  logic                        out_ok;
  logic                        tick_state;
  logic [HW-1:0]               half_eff;
  logic [HW-1:0]               half_lim;
  logic [HW-1:0]               tick_inc;
  logic                        phase_end;
  logic [PCW-1:0]              pulse_inc;
  logic [PCW-1:0]              pulse_target;
  logic                        last_pulse;
  logic [lcr_pkg::COUNT_W-1:0] readings_inc;
  logic                        last_reading;

  always_comb begin
    out_ok     = !out_valid || out_ready;
    tick_state = (state == S_IDLE) || (state == S_WAIT) || (state == S_HIGH) ||
                 (state == S_LOW);
    in_ready   = tick_state && out_ok;
    accept     = in_valid && in_ready;

    // Half period: zero counts as one, and it never exceeds what the counter can reach.
    half_lim  = HW'(1) << TCW;
    half_eff  = (cfg.half_period_ticks == '0) ? HW'(1) : HW'(cfg.half_period_ticks);
    if (half_eff > half_lim) begin
      half_eff = half_lim;
    end
    tick_inc  = HW'(tick_cnt) + HW'(1);
    phase_end = tick_inc >= half_eff;

    pulse_inc    = pulse_cnt + PCW'(1);
    pulse_target = PCW'(DATA_BITS) +
                   ((cfg.gain_pulses == '0) ? PCW'(1) : PCW'(cfg.gain_pulses));
    last_pulse   = pulse_inc >= pulse_target;
    readings_inc = readings + lcr_pkg::COUNT_W'(1);
    last_reading = readings_inc >= lcr_pkg::eff_count(cfg.average_count);
  end

  always_comb begin
    state_next     = state;
    tick_cnt_next  = tick_cnt;
    pulse_cnt_next = pulse_cnt;
    readings_next  = readings;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.shift_bit  = dout_level;

    if (accept) begin
      cmd.sck        = (state == S_HIGH) || power_down;
      cmd.out_tick   = 1'b1;
      out_valid_next = 1'b1;
      if (power_down) begin
        state_next     = S_IDLE;
        tick_cnt_next  = '0;
        pulse_cnt_next = '0;
        readings_next  = '0;
        cmd.shift_clr  = 1'b1;
        cmd.sum_clr    = 1'b1;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (start_measure) begin
              state_next     = S_WAIT;
              tick_cnt_next  = '0;
              pulse_cnt_next = '0;
              readings_next  = '0;
              cmd.shift_clr  = 1'b1;
              cmd.sum_clr    = 1'b1;
            end
          end
          S_WAIT: begin
            if (!dout_level) begin
              state_next     = S_HIGH;
              tick_cnt_next  = '0;
              pulse_cnt_next = '0;
              cmd.shift_clr  = 1'b1;
            end
          end
          S_HIGH: begin
            if (phase_end) begin
              state_next    = S_LOW;
              tick_cnt_next = '0;
            end else begin
              tick_cnt_next = tick_inc[TCW-1:0];
            end
          end
          S_LOW: begin
            if (phase_end) begin
              tick_cnt_next = '0;
              cmd.shift_en  = pulse_cnt < PCW'(DATA_BITS);
              if (last_pulse) begin
                pulse_cnt_next = '0;
                cmd.sum_add    = 1'b1;
                if (last_reading) begin
                  // The result of this transaction waits for the divide and scale.
                  state_next     = S_DIV;
                  readings_next  = '0;
                  cmd.div_start  = 1'b1;
                  cmd.out_tick   = 1'b0;
                  out_valid_next = out_valid && !out_ready;
                end else begin
                  state_next    = S_WAIT;
                  readings_next = readings_inc;
                end
              end else begin
                state_next     = S_HIGH;
                pulse_cnt_next = pulse_inc;
              end
            end else begin
              tick_cnt_next = tick_inc[TCW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      cmd.busy = (state_next != S_IDLE);
    end else begin
      unique case (state)
        S_DIV: begin
          cmd.div_step = 1'b1;
          if (stat.div_last) begin
            state_next = S_NET;
          end
        end
        S_NET: begin
          cmd.net_load = 1'b1;
          state_next   = S_MUL;
        end
        S_MUL: begin
          cmd.mul_load = 1'b1;
          state_next   = S_PUSH;
        end
        S_PUSH: begin
          if (out_ok) begin
            cmd.out_result = 1'b1;
            cmd.sum_clr    = 1'b1;
            cmd.shift_clr  = 1'b1;
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tick_cnt  <= '0;
      pulse_cnt <= '0;
      readings  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      tick_cnt  <= tick_cnt_next;
      pulse_cnt <= pulse_cnt_next;
      readings  <= readings_next;
      out_valid <= out_valid_next;
    end
  end

  a_pulse_bound: assert property (@(posedge clk) disable iff (rst)
    pulse_cnt <= PCW'(DATA_BITS + 2))
    else $error("pulse count ran past the data and gain pulses");

  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && !stat.div_last |=> (state == S_DIV))
    else $error("divider left before its last step");

  a_push_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) && out_ok |=> out_valid && (state == S_IDLE))
    else $error("finished measurement was not presented");

endmodule

// ===== hdl/load_cell_adc_serial_reader.sv =====
// Top level of the load cell serial reader: configuration registers, controller, datapath.
//
// This block reads a 24-bit bridge converter over its two-wire serial link. Each sample
// transaction is one tick: it carries the sampled data pin, a start request and a
// power-down request, and produces exactly one result transaction with the serial clock
// level for that tick, a busy flag, and, on the tick that completes a measurement, the
// truncated mean of the readings, the mean minus the tare offset (floored at zero) and the
// net value times the Q16.16 scale reciprocal, shifted right by 16. On every other tick the
// three measurement fields are zero. A steady stream of ticks is taken at one per cycle
// while results are drained as fast. The tick that completes a measurement holds off new
// ticks until its result has been presented: the mean comes from a restoring divider that
// produces one quotient bit per cycle over the 32-bit sum, followed by the tare subtraction,
// the 24 by 32 bit multiply and the presentation of the result once the output is free.
// Configuration writes go straight to the registers and must only happen while no
// measurement is in progress.
module load_cell_adc_serial_reader #(
  parameter int DATA_BITS          = lcr_pkg::DATA_BITS_DEF,
  parameter int TICK_COUNTER_WIDTH = lcr_pkg::TICK_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  lcr_tick_if.sink                        sample,
  lcr_result_if.source                    result,
  input  logic                            cfg_write,
  input  logic [lcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lcr_pkg::lcr_cfg_t  cfg;
  lcr_pkg::lcr_cmd_t  cmd;
  lcr_pkg::lcr_stat_t stat;

  // Configuration registers. Each write keeps only as many low bits as the register has;
  // writes to indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_pulses       <= lcr_pkg::GAIN_RST;
      cfg.half_period_ticks <= lcr_pkg::HALF_RST;
      cfg.average_count     <= lcr_pkg::COUNT_RST;
      cfg.tare_offset       <= lcr_pkg::TARE_RST;
      cfg.scale_reciprocal  <= lcr_pkg::RECIP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lcr_pkg::CFG_GAIN_PULSES:   cfg.gain_pulses <= cfg_data[lcr_pkg::GAIN_W-1:0];
        lcr_pkg::CFG_HALF_PERIOD:   cfg.half_period_ticks <= cfg_data[lcr_pkg::HALF_W-1:0];
        lcr_pkg::CFG_AVERAGE_COUNT: cfg.average_count <= cfg_data[lcr_pkg::COUNT_W-1:0];
        lcr_pkg::CFG_TARE_OFFSET:   cfg.tare_offset <= cfg_data[lcr_pkg::RESULT_W-1:0];
        lcr_pkg::CFG_SCALE_RECIP:   cfg.scale_reciprocal <= cfg_data[lcr_pkg::RECIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller sequences the clock phases, counts pulses and readings, owns the
  // handshakes, and steps the datapath through the divide, tare and scale at the end.
  lcr_ctrl #(
    .DATA_BITS          (DATA_BITS),
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .dout_level    (sample.dout_level),
    .start_measure (sample.start_measure),
    .power_down    (sample.power_down),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .cfg           (cfg),
    .stat          (stat),
    .cmd           (cmd)
  );

  // The datapath holds the shifted-in bits, the running sum, the divider and the output
  // register whose fields form the result transaction.
  lcr_datapath #(
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .cfg          (cfg),
    .stat         (stat),
    .sck_level    (result.sck_level),
    .busy_res     (result.busy_res),
    .result_valid (result.result_valid),
    .raw_average  (result.raw_average),
    .net_value    (result.net_value),
    .scaled_units (result.scaled_units)
  );

  // Ticks that do not finish a measurement carry zero measurement fields.
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.result_valid |->
      (result.raw_average == '0) && (result.net_value == '0) && (result.scaled_units == '0))
    else $error("measurement fields not zero on an ordinary tick");

endmodule

// ===== tb/sv/tb_load_cell_adc_serial_reader.sv =====
// Self-checking testbench for the load cell serial reader: tick stimulus, prediction, scoreboard.
`timescale 1ns / 1ps

module tb_load_cell_adc_serial_reader;

  // The run is ended as a failure if it is still going after this many clock cycles.
  localparam int CYCLE_LIMIT = 1000000;
  // Number of random tick transactions the random part aims for. It always runs at least
  // three setting phases so that both the pause and the steady stretch take place.
  localparam int RANDOM_TICKS       = 600;
  localparam int RANDOM_PHASES      = 3;
  localparam int PHASE_MEASUREMENTS = 3;
  localparam logic [lcr_pkg::RESULT_W-1:0] SIGN_FLIP = 24'h800000;

  // One tick transaction as the converter link sees it.
  typedef struct packed {
    logic dout_level;
    logic start_measure;
    logic power_down;
  } tick_item_t;

  // One result transaction: the serial clock level and the measurement fields for one tick.
  typedef struct packed {
    logic                         sck_level;
    logic                         busy_res;
    logic                         result_valid;
    logic [lcr_pkg::RESULT_W-1:0] raw_average;
    logic [lcr_pkg::RESULT_W-1:0] net_value;
    logic [lcr_pkg::UNITS_W-1:0]  scaled_units;
  } tick_result_t;

  // Where the serial link stands between ticks.
  typedef enum logic [1:0] {
    LINK_IDLE,
    LINK_AWAIT_DATA,
    LINK_SCK_HIGH,
    LINK_SCK_LOW
  } link_phase_t;

  logic clk = 1'b0;
  logic rst;
  logic                            cfg_write;
  logic [lcr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lcr_pkg::CFG_DATA_W-1:0]  cfg_data;

  lcr_tick_if   tick_ch ();
  lcr_result_if res_ch ();

  load_cell_adc_serial_reader dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (tick_ch),
    .result    (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // A 4 ns clock: two nanoseconds low, two high.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the configuration registers, kept in step with every write.
  lcr_pkg::lcr_cfg_t cfg_shadow;

  // Predicted state of the link, advanced once per accepted tick transaction.
  link_phase_t                  link_phase;
  logic [lcr_pkg::HALF_W-1:0]   link_ticks;
  logic [4:0]                   link_pulses;
  logic [lcr_pkg::RESULT_W-1:0] link_shift;
  logic [lcr_pkg::COUNT_W-1:0]  link_readings;
  logic [lcr_pkg::SUM_W-1:0]    link_sum;

  // Ticks waiting to be driven, and the results that accepted ticks are owed.
  tick_item_t   ticks_to_send[$];
  tick_result_t tick_results_due[$];

  tick_item_t   next_tick;
  tick_item_t   accepted_tick;
  tick_result_t due;
  bit           tick_held;
  bit           steady_flow;

  int cycle_count;
  int ticks_queued;
  int ticks_accepted;
  int results_checked;
  int measurements_seen;
  int measurements_abandoned;
  int mismatches;

  // Prints one line per mismatch and counts every one of them.
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns: result %0d: %s is %0h, predicted %0h", $time, results_checked, what,
             got, want);
    mismatches++;
  endtask

  function automatic void clear_link();
    link_ticks    = '0;
    link_pulses   = '0;
    link_shift    = '0;
    link_readings = '0;
    link_sum      = '0;
  endfunction

  // Counts one tick of a clock phase and tells whether that phase has now run its length.
  // A programmed half period of zero counts as one tick.
  function automatic bit clock_phase_over();
    int half_len;
    half_len = (cfg_shadow.half_period_ticks == '0) ? 1 : int'(cfg_shadow.half_period_ticks);
    if (int'(link_ticks) + 1 >= half_len) begin
      link_ticks = '0;
      return 1'b1;
    end
    link_ticks = link_ticks + 1'b1;
    return 1'b0;
  endfunction

  // Advances the predicted link by one tick and returns the result that tick must produce.
  function automatic tick_result_t advance_reader(input tick_item_t t);
    tick_result_t                  r;
    int                            gain_len;
    int                            count_len;
    logic [lcr_pkg::SUM_W-1:0]     mean;
    logic [lcr_pkg::PRODUCT_W-1:0] product;
    r = '0;
    r.sck_level = (link_phase == LINK_SCK_HIGH);
    if (t.power_down) begin
      // Power-down holds the clock high and drops any measurement in progress.
      r.sck_level = 1'b1;
      if (link_phase != LINK_IDLE) measurements_abandoned++;
      link_phase = LINK_IDLE;
      clear_link();
    end else begin
      case (link_phase)
        LINK_IDLE: begin
          if (t.start_measure) begin
            clear_link();
            link_phase = LINK_AWAIT_DATA;
          end
        end
        LINK_AWAIT_DATA: begin
          // A low data pin means a conversion is ready to be clocked out.
          if (!t.dout_level) begin
            link_ticks  = '0;
            link_pulses = '0;
            link_shift  = '0;
            link_phase  = LINK_SCK_HIGH;
          end
        end
        LINK_SCK_HIGH: begin
          if (clock_phase_over()) link_phase = LINK_SCK_LOW;
        end
        LINK_SCK_LOW: begin
          if (clock_phase_over()) begin
            gain_len = (cfg_shadow.gain_pulses == '0) ? 1 : int'(cfg_shadow.gain_pulses);
            if (link_pulses < lcr_pkg::DATA_BITS_DEF) begin
              link_shift = {link_shift[lcr_pkg::RESULT_W-2:0], t.dout_level};
            end
            link_pulses = link_pulses + 1'b1;
            if (link_pulses >= lcr_pkg::DATA_BITS_DEF + gain_len) begin
              // The reading is complete: flip the top bit to go from two's complement to offset binary.
              count_len = (cfg_shadow.average_count == '0) ? 1 :
                          int'(cfg_shadow.average_count);
              link_sum = link_sum + {8'b0, link_shift ^ SIGN_FLIP};
              link_readings = link_readings + 1'b1;
              link_pulses = '0;
              if (link_readings >= count_len) begin
                mean = link_sum / lcr_pkg::SUM_W'(count_len);
                r.raw_average = mean[lcr_pkg::RESULT_W-1:0];
                r.net_value = (r.raw_average > cfg_shadow.tare_offset) ?
                              r.raw_average - cfg_shadow.tare_offset : '0;
                product = lcr_pkg::PRODUCT_W'(r.net_value) *
                          lcr_pkg::PRODUCT_W'(cfg_shadow.scale_reciprocal);
                r.scaled_units = product[lcr_pkg::FRAC_W +: lcr_pkg::UNITS_W];
                r.result_valid = 1'b1;
                link_phase = LINK_IDLE;
                clear_link();
              end else begin
                link_phase = LINK_AWAIT_DATA;
              end
            end else begin
              link_phase = LINK_SCK_HIGH;
            end
          end
        end
        default: link_phase = LINK_IDLE;
      endcase
    end
    r.busy_res = (link_phase != LINK_IDLE);
    return r;
  endfunction

  // Tick driver. A tick that has been offered stays on the channel until it is taken; between
  // ticks the channel idles at random unless a steady stretch is in force, and the payload
  // carries junk while valid is low.
  always @(negedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else if (!tick_held) begin
      if (ticks_to_send.size() != 0 && (steady_flow || $urandom_range(99) >= 30)) begin
        next_tick = ticks_to_send.pop_front();
        tick_ch.valid         <= 1'b1;
        tick_ch.dout_level    <= next_tick.dout_level;
        tick_ch.start_measure <= next_tick.start_measure;
        tick_ch.power_down    <= next_tick.power_down;
        tick_held = 1'b1;
      end else begin
        tick_ch.valid         <= 1'b0;
        tick_ch.dout_level    <= 1'($urandom_range(1));
        tick_ch.start_measure <= 1'($urandom_range(1));
        tick_ch.power_down    <= 1'($urandom_range(1));
      end
    end
  end

  // The result side stalls at random too, except during the steady stretch.
  always @(negedge clk) begin
    res_ch.ready <= !rst && (steady_flow || $urandom_range(99) >= 30);
  end

  // Prediction and checking share one clocked block. A tick is predicted before the result
  // check of the same edge; results are registered, so a result always leaves after its
  // tick was taken and finds its expectation waiting.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && tick_ch.valid && tick_ch.ready) begin
      accepted_tick = '{dout_level: tick_ch.dout_level, start_measure: tick_ch.start_measure,
                        power_down: tick_ch.power_down};
      tick_results_due.push_back(advance_reader(accepted_tick));
      tick_held = 1'b0;
      ticks_accepted++;
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_checked++;
      if (tick_results_due.size() == 0) begin
        flag_mismatch("result transaction with no tick behind it", 64'd0, 64'd0);
      end else begin
        due = tick_results_due.pop_front();
        if (res_ch.sck_level !== due.sck_level)
          flag_mismatch("sck_level", 64'(res_ch.sck_level), 64'(due.sck_level));
        if (res_ch.busy_res !== due.busy_res)
          flag_mismatch("busy_res", 64'(res_ch.busy_res), 64'(due.busy_res));
        if (res_ch.result_valid !== due.result_valid)
          flag_mismatch("result_valid", 64'(res_ch.result_valid), 64'(due.result_valid));
        if (res_ch.raw_average !== due.raw_average)
          flag_mismatch("raw_average", 64'(res_ch.raw_average), 64'(due.raw_average));
        if (res_ch.net_value !== due.net_value)
          flag_mismatch("net_value", 64'(res_ch.net_value), 64'(due.net_value));
        if (res_ch.scaled_units !== due.scaled_units)
          flag_mismatch("scaled_units", 64'(res_ch.scaled_units), 64'(due.scaled_units));
      end
      if (res_ch.result_valid === 1'b1) measurements_seen++;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results still owed.",
               tick_results_due.size());
      $display("load_cell_adc_serial_reader verification failed");
      $finish;
    end
  end

  task automatic send_tick(input tick_item_t t);
    while (ticks_to_send.size() >= 64) @(negedge clk);
    ticks_to_send.push_back(t);
    ticks_queued++;
  endtask

  // Waits until every queued tick has been taken and every owed result has come back.
  task automatic drain_results();
    do @(negedge clk);
    while (ticks_to_send.size() != 0 || ticks_accepted != ticks_queued ||
           tick_results_due.size() != 0);
  endtask

  // Brings the block to idle so that the registers may be written: drains, and if a
  // measurement is still open, drops it with a power-down tick.
  task automatic settle_reader();
    drain_results();
    if (link_phase != LINK_IDLE) begin
      send_tick('{dout_level: 1'b1, start_measure: 1'b0, power_down: 1'b1});
      drain_results();
    end
  endtask

  task automatic write_reg(input logic [lcr_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lcr_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      lcr_pkg::CFG_GAIN_PULSES:
        cfg_shadow.gain_pulses = data[lcr_pkg::GAIN_W-1:0];
      lcr_pkg::CFG_HALF_PERIOD:
        cfg_shadow.half_period_ticks = data[lcr_pkg::HALF_W-1:0];
      lcr_pkg::CFG_AVERAGE_COUNT:
        cfg_shadow.average_count = data[lcr_pkg::COUNT_W-1:0];
      lcr_pkg::CFG_TARE_OFFSET:
        cfg_shadow.tare_offset = data[lcr_pkg::RESULT_W-1:0];
      lcr_pkg::CFG_SCALE_RECIP:
        cfg_shadow.scale_reciprocal = data[lcr_pkg::RECIP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input logic [lcr_pkg::CFG_DATA_W-1:0] gain,
                            input logic [lcr_pkg::CFG_DATA_W-1:0] half,
                            input logic [lcr_pkg::CFG_DATA_W-1:0] count,
                            input logic [lcr_pkg::CFG_DATA_W-1:0] tare,
                            input logic [lcr_pkg::CFG_DATA_W-1:0] recip);
    settle_reader();
    write_reg(lcr_pkg::CFG_GAIN_PULSES, gain);
    write_reg(lcr_pkg::CFG_HALF_PERIOD, half);
    write_reg(lcr_pkg::CFG_AVERAGE_COUNT, count);
    write_reg(lcr_pkg::CFG_TARE_OFFSET, tare);
    write_reg(lcr_pkg::CFG_SCALE_RECIP, recip);
  endtask

  // A tick inside a measurement: start requests are thrown in since they must be ignored.
  function automatic tick_item_t busy_tick(input logic dout);
    return '{dout_level: dout, start_measure: 1'($urandom_range(1)), power_down: 1'b0};
  endfunction

  // Reading words lean toward the extremes of the converter range.
  function automatic logic [lcr_pkg::RESULT_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h800000;
      3: return 24'h7FFFFF;
      default: return lcr_pkg::RESULT_W'($urandom);
    endcase
  endfunction

  // Queues one well-formed measurement, timed against the current settings so that each data
  // bit lands on the last tick of a low clock phase. When a break is allowed, about one
  // measurement in eight is cut short at a random tick by a power-down.
  task automatic queue_measurement(input bit use_fixed,
                                   input logic [lcr_pkg::RESULT_W-1:0] fixed_word,
                                   input bit may_break);
    tick_item_t                   seq[$];
    tick_item_t                   t;
    logic [lcr_pkg::RESULT_W-1:0] word;
    int                           half_len;
    int                           gain_len;
    int                           count_len;
    int                           cut;
    half_len  = (cfg_shadow.half_period_ticks == '0) ? 1 : int'(cfg_shadow.half_period_ticks);
    gain_len  = (cfg_shadow.gain_pulses == '0) ? 1 : int'(cfg_shadow.gain_pulses);
    count_len = (cfg_shadow.average_count == '0) ? 1 : int'(cfg_shadow.average_count);
    repeat ($urandom_range(3)) begin
      t.dout_level    = 1'($urandom_range(1));
      t.power_down    = ($urandom_range(19) == 0);
      t.start_measure = t.power_down ? 1'($urandom_range(1)) : 1'b0;
      seq.push_back(t);
    end
    seq.push_back('{dout_level: 1'($urandom_range(1)), start_measure: 1'b1, power_down: 1'b0});
    for (int r = 0; r < count_len; r++) begin
      word = use_fixed ? fixed_word : pick_word();
      repeat ($urandom_range(4)) seq.push_back(busy_tick(1'b1));
      seq.push_back(busy_tick(1'b0));
      for (int p = 0; p < lcr_pkg::DATA_BITS_DEF + gain_len; p++) begin
        repeat (2 * half_len - 1) seq.push_back(busy_tick(1'($urandom_range(1))));
        seq.push_back(busy_tick(p < lcr_pkg::DATA_BITS_DEF ?
                                word[lcr_pkg::DATA_BITS_DEF-1-p] : 1'($urandom_range(1))));
      end
    end
    cut = seq.size();
    if (may_break && $urandom_range(99) < 12) cut = $urandom_range(1, seq.size() - 1);
    for (int i = 0; i < cut; i++) send_tick(seq[i]);
    if (cut < seq.size())
      send_tick('{dout_level: 1'($urandom_range(1)), start_measure: 1'($urandom_range(1)),
                  power_down: 1'b1});
  endtask

  initial begin
    int                              random_start;
    int                              phase_no;
    logic [lcr_pkg::CFG_DATA_W-1:0]  half_pick;
    logic [lcr_pkg::CFG_DATA_W-1:0]  count_pick;
    logic [lcr_pkg::CFG_DATA_W-1:0]  recip_pick;

    rst                   = 1'b1;
    cfg_write             = 1'b0;
    cfg_index             = lcr_pkg::CFG_GAIN_PULSES;
    cfg_data              = '0;
    tick_ch.valid         = 1'b0;
    tick_ch.dout_level    = 1'b1;
    tick_ch.start_measure = 1'b0;
    tick_ch.power_down    = 1'b0;
    res_ch.ready          = 1'b0;
    cfg_shadow = '{gain_pulses: lcr_pkg::GAIN_RST, half_period_ticks: lcr_pkg::HALF_RST,
                   average_count: lcr_pkg::COUNT_RST, tare_offset: lcr_pkg::TARE_RST,
                   scale_reciprocal: lcr_pkg::RECIP_RST};
    link_phase = LINK_IDLE;
    clear_link();

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // With the reset settings: an idle tick, power-down alone and with a start request (the
    // start must be ignored), a real start, a second start while busy, a wait on a high data
    // pin, then clocking across the 20-tick phase boundary before a power-down abandons it.
    send_tick('{dout_level: 1'b1, start_measure: 1'b0, power_down: 1'b0});
    send_tick('{dout_level: 1'b1, start_measure: 1'b0, power_down: 1'b1});
    send_tick('{dout_level: 1'b0, start_measure: 1'b1, power_down: 1'b1});
    send_tick('{dout_level: 1'b1, start_measure: 1'b1, power_down: 1'b0});
    send_tick('{dout_level: 1'b1, start_measure: 1'b1, power_down: 1'b0});
    send_tick('{dout_level: 1'b1, start_measure: 1'b0, power_down: 1'b0});
    send_tick('{dout_level: 1'b0, start_measure: 1'b0, power_down: 1'b0});
    repeat (45) send_tick(busy_tick(1'($urandom_range(1))));
    send_tick('{dout_level: 1'b0, start_measure: 1'b0, power_down: 1'b1});

    // Zero gain, half period and count all fall back to one; the four corner readings.
    set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000);
    queue_measurement(1'b1, 24'hFFFFFF, 1'b0);
    queue_measurement(1'b1, 24'h000000, 1'b0);
    queue_measurement(1'b1, 24'h800000, 1'b0);
    queue_measurement(1'b1, 24'h7FFFFF, 1'b0);

    // Largest tare with the largest scale: the net value is floored at zero.
    set_config(32'd3, 32'd1, 32'd2, 32'h00FF_FFFF, 32'hFFFF_FFFF);
    queue_measurement(1'b1, 24'hFFFFFF, 1'b0);
    queue_measurement(1'b0, 24'h0, 1'b0);

    // No tare with the largest scale: the top reading gives the largest unit value, and a
    // mean equal to the tare gives zero.
    set_config(32'd2, 32'd2, 32'd1, 32'd0, 32'hFFFF_FFFF);
    queue_measurement(1'b1, 24'h7FFFFF, 1'b0);
    queue_measurement(1'b1, 24'h800000, 1'b0);

    // A longer average over a count that is not a power of two, with a zero scale.
    set_config(32'd1, 32'd1, 32'd5, 32'h0000_0100, 32'd0);
    queue_measurement(1'b0, 24'h0, 1'b0);

    // The longest half period: only the first clock phase is run before a power-down.
    set_config(32'd1, 32'd65535, 32'd1, 32'd0, 32'h0001_0000);
    send_tick('{dout_level: 1'b1, start_measure: 1'b1, power_down: 1'b0});
    send_tick('{dout_level: 1'b0, start_measure: 1'b0, power_down: 1'b0});
    repeat (60) send_tick(busy_tick(1'($urandom_range(1))));
    send_tick('{dout_level: 1'b1, start_measure: 1'b0, power_down: 1'b1});

    // Random settings, each held for a few measurements. Short half periods and small counts
    // keep measurements quick; junk in the unused data bits must be dropped. One phase runs
    // with no idling on either side, and in another the sender stops mid-phase until every
    // owed result is back.
    random_start = ticks_queued;
    phase_no = 0;
    while (ticks_queued - random_start < RANDOM_TICKS || phase_no < RANDOM_PHASES) begin
      half_pick  = ($urandom_range(19) == 0) ? $urandom_range(3, 5) : $urandom_range(1);
      count_pick = ($urandom_range(7) == 0) ? $urandom_range(2, 4) : $urandom_range(1);
      recip_pick = ($urandom_range(3) == 0) ? 32'h0001_0000 : 32'($urandom);
      set_config(($urandom & ~32'h3) | $urandom_range(3),
                 ($urandom & 32'hFFFF_0000) | half_pick,
                 ($urandom & 32'hFFFF_FF00) | count_pick,
                 $urandom, recip_pick);
      steady_flow = (phase_no == 2);
      for (int m = 0; m < PHASE_MEASUREMENTS; m++) begin
        queue_measurement(1'b0, 24'h0, 1'b1);
        if (phase_no == 1 && m == 1) drain_results();
      end
      drain_results();
      steady_flow = 1'b0;
      phase_no++;
    end

    drain_results();
    repeat (40) @(negedge clk);

    $display("Checked %0d tick transactions over %0d setting phases in %0d cycles.",
             results_checked, phase_no + 6, cycle_count);
    $display("Saw %0d finished measurements; %0d were dropped by power-down.",
             measurements_seen, measurements_abandoned);
    if (mismatches == 0) begin
      $display("load_cell_adc_serial_reader verification clean");
    end else begin
      $display("load_cell_adc_serial_reader verification failed");
    end
    $finish;
  end

endmodule
